>>> sv/pctd_pkg.sv
// Shared constants and types for the prime counting block.
`default_nettype none

package pctd_pkg;

   // Default width of the range bounds and of the count.
   localparam int VALUE_BITS_DEFAULT = 20;

   // Status that the bit-serial remainder unit reports to the sequencer.
   typedef struct packed {
      logic done;       // one-cycle pulse: the remainder is final
      logic rem_zero;   // the divisor divides the dividend exactly
   } div_status_type;

endpackage

`default_nettype wire

>>> sv/prime_count_trial_division.sv
// Counts the primes in [low, high) by trial division with odd divisors.
// One item is worked on at a time; the bit-serial remainder unit sets the rate.
// The result waits in an output register while the next item is taken.
// Synchronous reset clears the sequencer and the result valid flag.
`default_nettype none

module prime_count_trial_division #(
   parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VALUE_BITS-1:0]  req_range_low,
   input  wire logic [VALUE_BITS-1:0]  req_range_high,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VALUE_BITS-1:0]       rsp_prime_count
);

   localparam int SQW = VALUE_BITS + 2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CAND = 5'b00010,
      ST_TEST = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [VALUE_BITS-1:0] high_ff, high_in;
   logic [VALUE_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [SQW-1:0]        sq_ff, sq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_take;
   logic                  div_start;
   logic [SQW-1:0]        v_wide;
   pctd_pkg::div_status_type div_status;

   assign v_wide   = {2'b00, v_ff};
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      high_in      = high_ff;
      count_in     = count_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_count_in = rsp_count_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               v_in     = req_range_low;
               high_in  = req_range_high;
               count_in = '0;
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (v_ff >= high_ff) begin
               state_in = ST_DONE;
            end else if (v_wide < SQW'(2)) begin
               v_in = v_ff + VALUE_BITS'(1);
            end else if (v_wide < SQW'(4)) begin
               count_in = count_ff + VALUE_BITS'(1);
               v_in     = v_ff + VALUE_BITS'(1);
            end else if (!v_ff[0]) begin
               v_in = v_ff + VALUE_BITS'(1);
            end else begin
               d_in     = VALUE_BITS'(3);
               sq_in    = SQW'(9);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            // No divisor up to the square root: the candidate is prime.
            if (sq_ff > v_wide) begin
               count_in = count_ff + VALUE_BITS'(1);
               v_in     = v_ff + VALUE_BITS'(1);
               state_in = ST_CAND;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  v_in     = v_ff + VALUE_BITS'(1);
                  state_in = ST_CAND;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  d_in     = d_ff + VALUE_BITS'(2);
                  sq_in    = sq_ff + {d_ff, 2'b00} + SQW'(4);
                  state_in = ST_TEST;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      high_ff      <= high_in;
      count_ff     <= count_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   pctd_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (v_ff),
      .divisor  (d_ff),
      .status   (div_status)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

   a_div_start_ok: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (sq_ff <= v_wide) && v_ff[0])
      else $error("trial division started past the square root or on an even value");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("remainder reported outside the divide state");

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |-> d_ff[0] && (d_ff >= VALUE_BITS'(3)))
      else $error("trial divisor is not an odd value of at least three");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CAND |-> count_ff <= v_ff)
      else $error("prime count exceeds the candidate value");

endmodule

`default_nettype wire

>>> sv/pctd_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module pctd_divider #(
   parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_BITS-1:0]  dividend,
   input  wire logic [VALUE_BITS-1:0]  divisor,
   output pctd_pkg::div_status_type    status
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS:0]   trial;

   // The partial remainder stays below the divisor, so one compare and
   // subtract per bit is enough.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[VALUE_BITS-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         cnt_in   = CW'(VALUE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VALUE_BITS'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder unit reports done while still busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0) && (cnt_ff <= CW'(VALUE_BITS)))
      else $error("remainder unit bit counter out of range while busy");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the trial-division prime counter.
`timescale 1ns / 100ps

module tb;

   localparam int VALUE_BITS = pctd_pkg::VALUE_BITS_DEFAULT;
   localparam int unsigned VALUE_MAX = (1 << VALUE_BITS) - 1;
   localparam int unsigned WATCHDOG_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 100;

   typedef struct {
      logic [VALUE_BITS-1:0] low;
      logic [VALUE_BITS-1:0] high;
      bit                    drain;
   } range_item_type;

   typedef struct {
      logic [VALUE_BITS-1:0] low;
      logic [VALUE_BITS-1:0] high;
      logic [VALUE_BITS-1:0] count;
   } expected_count_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_range_low = '0;
   logic [VALUE_BITS-1:0] req_range_high = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_prime_count;

   range_item_type     pending_ranges[$];
   expected_count_type expected_counts[$];
   range_item_type     next_range;
   expected_count_type accepted_range;
   expected_count_type oldest_count;

   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_timer = 0;
   int unsigned stall_mode = 0;
   int unsigned idle_cycles = 0;
   int unsigned error_count = 0;

   prime_count_trial_division #(
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_count(rsp_prime_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit value_is_prime(input int unsigned v);
      int unsigned d;
      if (v < 2) return 1'b0;
      if (v < 4) return 1'b1;
      if (v % 2 == 0) return 1'b0;
      for (d = 3; d * d <= v; d += 2) begin
         if (v % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [VALUE_BITS-1:0] primes_in_range(
      input logic [VALUE_BITS-1:0] low,
      input logic [VALUE_BITS-1:0] high
   );
      int unsigned v;
      int unsigned n;
      n = 0;
      for (v = low; v < high; v++) begin
         if (value_is_prime(v)) n++;
      end
      return n[VALUE_BITS-1:0];
   endfunction

   // Large candidates are kept to ones with a small factor, so the search
   // for each stops early and the run stays short.
   function automatic bit all_have_small_factor(input int unsigned low, input int unsigned high);
      int unsigned v;
      int unsigned d;
      bit found;
      for (v = low; v < high; v++) begin
         found = 1'b0;
         for (d = 2; d <= 31; d++) begin
            if (v % d == 0 && v != d) found = 1'b1;
         end
         if (!found) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic add_range(input int unsigned low, input int unsigned high, input bit drain);
      range_item_type r;
      r.low = low[VALUE_BITS-1:0];
      r.high = high[VALUE_BITS-1:0];
      r.drain = drain;
      pending_ranges.push_back(r);
   endtask

   // Sender: bursts of items with random gaps, plus an occasional drain pause.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_range.low = req_range_low;
            accepted_range.high = req_range_high;
            accepted_range.count = primes_in_range(req_range_low, req_range_high);
            expected_counts.push_back(accepted_range);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ranges.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_ranges[0].drain && expected_counts.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               next_range = pending_ranges.pop_front();
               req_range_low <= next_range.low;
               req_range_high <= next_range.high;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 10);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Receiver stall pattern: stretches with no stall, random stalls and square waves.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_timer = $urandom_range(16, 80);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            rsp_stall <= stall_timer[2];
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected prime count item: expected none, actual %0d",
                     $time, rsp_prime_count);
            error_count++;
         end else begin
            oldest_count = expected_counts.pop_front();
            if (rsp_prime_count !== oldest_count.count) begin
               $display("%0t: prime count for [%0d, %0d): expected %0d, actual %0d",
                        $time, oldest_count.low, oldest_count.high, oldest_count.count,
                        rsp_prime_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("prime_count_trial_division regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned low;
      int unsigned high;
      int unsigned len;
      int unsigned pick;
      int unsigned i;

      // Empty, reversed, single-candidate and wider ranges from 0 to the top value.
      add_range(0, 0, 1'b0);
      add_range(0, 1, 1'b0);
      add_range(0, 2, 1'b0);
      add_range(0, 3, 1'b0);
      add_range(1, 2, 1'b0);
      add_range(2, 3, 1'b0);
      add_range(3, 4, 1'b0);
      add_range(4, 5, 1'b0);
      add_range(2, 4, 1'b0);
      add_range(0, 100, 1'b1);
      add_range(97, 98, 1'b0);
      add_range(90, 97, 1'b0);
      add_range(10, 3, 1'b0);
      add_range(5, 5, 1'b0);
      add_range(VALUE_MAX, 0, 1'b0);
      add_range(VALUE_MAX, VALUE_MAX, 1'b0);
      add_range(VALUE_MAX - 1, VALUE_MAX, 1'b0);
      add_range(VALUE_MAX - 5, VALUE_MAX - 4, 1'b0);
      add_range('hAAAAA, 'h55555, 1'b0);
      add_range(1000, 1024, 1'b0);
      add_range(4090, 4096, 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 6) == 0) begin
               low = $urandom_range(0, 4096);
               len = $urandom_range(0, 12);
            end else if ($urandom_range(0, 9) == 0) begin
               low = $urandom_range(0, 300);
               len = $urandom_range(25, 60);
            end else begin
               low = $urandom_range(0, 600);
               len = $urandom_range(0, 24);
            end
            high = low + len;
         end else if (pick < 85) begin
            // Reversed or empty ranges carry full-width random values cheaply.
            low = $urandom & VALUE_MAX;
            high = $urandom & VALUE_MAX;
            if ($urandom_range(0, 4) == 0) high = low;
            if (low < high) begin
               len = low;
               low = high;
               high = len;
            end
         end else begin
            do begin
               low = $urandom_range(32, VALUE_MAX - 3);
               len = $urandom_range(1, 3);
            end while (!all_have_small_factor(low, low + len));
            high = low + len;
         end
         add_range(low, high, (i == 0) || (i == RANDOM_ITEMS / 2) || ($urandom_range(0, 24) == 0));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (pending_ranges.size() != 0 || req_valid || expected_counts.size() != 0);
      repeat (50) @(posedge clock);

      if (error_count == 0) begin
         $display("prime_count_trial_division regression: pass");
      end else begin
         $display("prime_count_trial_division regression: fail");
      end
      $finish;
   end

endmodule
